// ===== hdl/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants of the 4x4 matrix vector transform
// Payload structs, datapath widths and register map of the transform unit.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int ELEM_W      = 32;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int ACC_W       = PROD_W + 2;
    localparam int REG_W       = 64;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLS    = 4;
    localparam int NUM_REGS    = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_SEL_W   = $clog2(NUM_REGS);

    localparam logic signed [ELEM_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [ELEM_W-1:0] SAT_MIN = 32'sh8000_0000;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0_COLS01 = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_COLS01 = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2_COLS23 = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3_COLS23 = 4'd7;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] in_x;
        logic signed [ELEM_W-1:0] in_y;
        logic signed [ELEM_W-1:0] in_z;
        logic signed [ELEM_W-1:0] in_w;
    } mvt_in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] out_x;
        logic signed [ELEM_W-1:0] out_y;
        logic signed [ELEM_W-1:0] out_z;
        logic signed [ELEM_W-1:0] out_w;
        logic                     saturated;
    } mvt_out_t;

    // stage load enables handed to the row datapaths
    typedef struct packed {
        logic mul;
        logic pair;
        logic sum;
    } mvt_adv_t;

endpackage

// ===== hdl/mvt_row.sv =====
// ----------------------------------------------------------------------------
// mvt_row: pipelined dot product of one matrix row with the input vector
// Products, pair sums and the full row sum are registered stages; the floor
// shift and 32-bit saturation of the row sum are left for the output register.
// ----------------------------------------------------------------------------
module mvt_row #(
    parameter int COLS      = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  mvt_pkg::mvt_adv_t             adv,
    input  mvt_pkg::mvt_in_t              vec,
    input  logic [mvt_pkg::REG_W-1:0]     cols01,
    input  logic [mvt_pkg::REG_W-1:0]     cols23,
    output logic signed [mvt_pkg::ELEM_W-1:0] res,
    output logic                          sat
);

    localparam int ELEM_W = mvt_pkg::ELEM_W;
    localparam int ACC_W  = mvt_pkg::ACC_W;

    mvt_pkg::elem_t elem  [mvt_pkg::NUM_COLS];
    mvt_pkg::elem_t vcomp [mvt_pkg::NUM_COLS];
    mvt_pkg::prod_t prod_reg  [mvt_pkg::NUM_COLS];
    mvt_pkg::prod_t prod_next [mvt_pkg::NUM_COLS];
    mvt_pkg::pair_t pair_reg  [2];
    mvt_pkg::pair_t pair_next [2];
    mvt_pkg::acc_t  sum_reg;
    mvt_pkg::acc_t  sum_next;
    mvt_pkg::acc_t  shifted;
    logic           pos_ovf;
    logic           neg_ovf;

    always_comb
    begin
        elem[0]  = cols01[ELEM_W-1:0];
        elem[1]  = cols01[2*ELEM_W-1:ELEM_W];
        elem[2]  = cols23[ELEM_W-1:0];
        elem[3]  = cols23[2*ELEM_W-1:ELEM_W];
        vcomp[0] = vec.in_x;
        vcomp[1] = vec.in_y;
        vcomp[2] = vec.in_z;
        vcomp[3] = vec.in_w;

        // columns beyond the active dimension contribute nothing
        for (int j = 0; j < mvt_pkg::NUM_COLS; j++)
        begin
            if (j < COLS)
                prod_next[j] = elem[j] * vcomp[j];
            else
                prod_next[j] = '0;
        end

        pair_next[0] = mvt_pkg::pair_t'(prod_reg[0]) + mvt_pkg::pair_t'(prod_reg[1]);
        pair_next[1] = mvt_pkg::pair_t'(prod_reg[2]) + mvt_pkg::pair_t'(prod_reg[3]);
        sum_next     = mvt_pkg::acc_t'(pair_reg[0]) + mvt_pkg::acc_t'(pair_reg[1]);

        // arithmetic shift floors toward minus infinity
        shifted = sum_reg >>> FRAC_BITS;
        pos_ovf = !shifted[ACC_W-1] && (|shifted[ACC_W-2:ELEM_W-1]);
        neg_ovf = shifted[ACC_W-1] && !(&shifted[ACC_W-2:ELEM_W-1]);

        if (pos_ovf)
            res = mvt_pkg::SAT_MAX;
        else if (neg_ovf)
            res = mvt_pkg::SAT_MIN;
        else
            res = shifted[ELEM_W-1:0];
        sat = pos_ovf || neg_ovf;
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul)
            prod_reg <= prod_next;
        if (adv.pair)
            pair_reg <= pair_next;
        if (adv.sum)
            sum_reg <= sum_next;
    end

endmodule

// ===== hdl/matrix_vector_transform_4x4_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_unit: streaming 4x4 matrix times vector
// Multiplies each Q15.16 input vector by the configured matrix, with floor
// shift and 32-bit saturation of every row.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_stall carry one vector per transaction
//   out channel: out_valid / out_stall carry the four row results plus a
//     saturated flag set when any row was clipped
//   cfg channel: cfg_valid / cfg_ready write one 64-bit matrix register
//     (two elements, lower column in bits 31:0); cfg_ready is always high,
//     indexes of 8 and up are dropped; write only while the pipe is empty
//   latency: 4 cycles from input transaction to out_valid (product stage,
//     pair add, row add, shift/saturate output register)
//   throughput: one vector per cycle; every stage holds one item and the
//     16 multipliers of the product stage work on a new vector each cycle
//   stall: a stalled output holds its result; stages behind it keep filling
//     bubbles, and in_stall rises only once all four stages are occupied
//   reset: pipeline empties, matrix returns to identity
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_unit #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mvt_pkg::mvt_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mvt_pkg::mvt_out_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mvt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mvt_pkg::REG_W-1:0]           cfg_data
);

    localparam logic [mvt_pkg::REG_W-1:0] ONE_LO = mvt_pkg::REG_W'(1) << FRAC_BITS;
    localparam logic [mvt_pkg::REG_W-1:0] ONE_HI = ONE_LO << mvt_pkg::ELEM_W;

    logic [mvt_pkg::REG_W-1:0] mat_reg [mvt_pkg::NUM_REGS];

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic out_valid_reg, out_valid_next;
    logic en_out;

    mvt_pkg::mvt_adv_t adv;
    mvt_pkg::mvt_out_t out_data_reg;
    mvt_pkg::mvt_out_t out_data_next;

    logic signed [mvt_pkg::ELEM_W-1:0] row_res [mvt_pkg::NUM_ROWS];
    logic                              row_sat [mvt_pkg::NUM_ROWS];

    // each stage moves when it is empty or the stage ahead moves
    always_comb
    begin
        en_out   = !out_valid_reg || !out_stall;
        adv.sum  = !s3_valid_reg || en_out;
        adv.pair = !s2_valid_reg || adv.sum;
        adv.mul  = !s1_valid_reg || adv.pair;

        s1_valid_next  = adv.mul  ? in_valid     : s1_valid_reg;
        s2_valid_next  = adv.pair ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = adv.sum  ? s2_valid_reg : s3_valid_reg;
        out_valid_next = en_out   ? s3_valid_reg : out_valid_reg;

        out_data_next.out_x     = row_res[0];
        out_data_next.out_y     = row_res[1];
        out_data_next.out_z     = row_res[2];
        out_data_next.out_w     = row_res[3];
        out_data_next.saturated = row_sat[0] || row_sat[1] || row_sat[2] || row_sat[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
            begin
                mat_reg[i] <= '0;
            end
            mat_reg[mvt_pkg::REG_ROW0_COLS01[mvt_pkg::CFG_SEL_W-1:0]] <= ONE_LO;
            mat_reg[mvt_pkg::REG_ROW1_COLS01[mvt_pkg::CFG_SEL_W-1:0]] <= ONE_HI;
            mat_reg[mvt_pkg::REG_ROW2_COLS23[mvt_pkg::CFG_SEL_W-1:0]] <= ONE_LO;
            mat_reg[mvt_pkg::REG_ROW3_COLS23[mvt_pkg::CFG_SEL_W-1:0]] <= ONE_HI;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready
                && (cfg_index < mvt_pkg::CFG_INDEX_W'(mvt_pkg::NUM_REGS)))
                mat_reg[cfg_index[mvt_pkg::CFG_SEL_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
            out_data_reg <= out_data_next;
    end

    for (genvar r = 0; r < mvt_pkg::NUM_ROWS; r++)
    begin : g_row
        if (r < DIM)
        begin : g_active
            mvt_row #(
                .COLS      (DIM),
                .FRAC_BITS (FRAC_BITS)
            ) u_row (
                .clk    (clk),
                .adv    (adv),
                .vec    (in_data),
                .cols01 (mat_reg[2*r]),
                .cols23 (mat_reg[2*r+1]),
                .res    (row_res[r]),
                .sat    (row_sat[r])
            );
        end
        else
        begin : g_unused
            // rows beyond the active dimension read as zero
            assign row_res[r] = '0;
            assign row_sat[r] = 1'b0;
        end
    end

    assign in_stall  = !adv.mul;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== hdl/mvt_checker.sv =====
// ----------------------------------------------------------------------------
// mvt_checker: port-level checks of the matrix vector transform unit
// Watches the handshakes and result payload and flags behavior that the
// pipeline must never show.
// ----------------------------------------------------------------------------
module mvt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input mvt_pkg::mvt_out_t               out_data,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // input backpressure only comes from a stalled result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output side is free");

    // a saturated result carries at least one clipped component
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            (out_data.out_x == mvt_pkg::SAT_MAX) || (out_data.out_x == mvt_pkg::SAT_MIN) ||
            (out_data.out_y == mvt_pkg::SAT_MAX) || (out_data.out_y == mvt_pkg::SAT_MIN) ||
            (out_data.out_z == mvt_pkg::SAT_MAX) || (out_data.out_z == mvt_pkg::SAT_MIN) ||
            (out_data.out_w == mvt_pkg::SAT_MAX) || (out_data.out_w == mvt_pkg::SAT_MIN))
        else $error("saturated flag without a clipped component");

    // configuration writes are never held off
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

    // pipe is idle right after reset releases
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid straight out of reset");

endmodule

bind matrix_vector_transform_4x4_unit mvt_checker u_mvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== verif/tb_matrix_vector_transform_4x4_unit.sv =====
// ----------------------------------------------------------------------------
// tb_matrix_vector_transform_4x4_unit: self-checking bench of the 4x4 transform
// Loads matrices through the config channel and streams vectors in with random
// gaps and output stalls. Every accepted vector is run through a local Q15.16
// transform model, and each output transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb_matrix_vector_transform_4x4_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM             = 4;
    localparam int FRAC_BITS       = 16;
    localparam int PIPE_LATENCY    = 4;
    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 73;
    localparam int SUM_W           = mvt_pkg::ACC_W + 4;

    localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW0_COLS23 = 4'd1;
    localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW1_COLS23 = 4'd3;
    localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW2_COLS01 = 4'd4;
    localparam logic [mvt_pkg::CFG_INDEX_W-1:0] REG_ROW3_COLS01 = 4'd6;

    localparam mvt_pkg::elem_t FIX_ONE = mvt_pkg::elem_t'(1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] ROW_MAX = SUM_W'(mvt_pkg::SAT_MAX);
    localparam logic signed [SUM_W-1:0] ROW_MIN = SUM_W'(mvt_pkg::SAT_MIN);

    typedef enum int {VAL_FULL, VAL_SMALL, VAL_EXTREME, VAL_MIXED} val_kind_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    mvt_pkg::mvt_in_t                in_data;
    logic                            out_valid;
    logic                            out_stall;
    mvt_pkg::mvt_out_t               out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [mvt_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mvt_pkg::REG_W-1:0]       cfg_data;

    logic [mvt_pkg::REG_W-1:0] matrix_regs [mvt_pkg::NUM_REGS];
    mvt_pkg::mvt_out_t         pending_results [$];
    mvt_pkg::mvt_out_t         oldest_result;
    int                        mismatch_count = 0;
    int                        idle_cycles = 0;
    bit                        sender_gaps;

    matrix_vector_transform_4x4_unit #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic mvt_pkg::elem_t matrix_elem(int row, int col);
        logic [mvt_pkg::REG_W-1:0] pair;
        pair = matrix_regs[row * 2 + col / 2];
        return (col % 2) ? mvt_pkg::elem_t'(pair[63:32]) : mvt_pkg::elem_t'(pair[31:0]);
    endfunction

    // exact row sums, floor shift, then clip to 32 bits
    function automatic mvt_pkg::mvt_out_t transform_vector(mvt_pkg::mvt_in_t vec);
        mvt_pkg::elem_t           comp [mvt_pkg::NUM_COLS];
        mvt_pkg::elem_t           rows [mvt_pkg::NUM_ROWS];
        logic signed [SUM_W-1:0]  acc;
        logic signed [SUM_W-1:0]  shifted;
        logic                     clipped;
        mvt_pkg::mvt_out_t        res;
        comp[0] = vec.in_x;
        comp[1] = vec.in_y;
        comp[2] = vec.in_z;
        comp[3] = vec.in_w;
        clipped = 1'b0;
        for (int r = 0; r < mvt_pkg::NUM_ROWS; r++)
        begin
            rows[r] = '0;
            if (r < DIM)
            begin
                acc = '0;
                for (int c = 0; c < DIM; c++)
                    acc = acc + SUM_W'(matrix_elem(r, c)) * SUM_W'(comp[c]);
                shifted = acc >>> FRAC_BITS;
                if (shifted > ROW_MAX)
                begin
                    rows[r] = mvt_pkg::SAT_MAX;
                    clipped = 1'b1;
                end
                else if (shifted < ROW_MIN)
                begin
                    rows[r] = mvt_pkg::SAT_MIN;
                    clipped = 1'b1;
                end
                else
                    rows[r] = mvt_pkg::elem_t'(shifted[mvt_pkg::ELEM_W-1:0]);
            end
        end
        res.out_x     = rows[0];
        res.out_y     = rows[1];
        res.out_z     = rows[2];
        res.out_w     = rows[3];
        res.saturated = clipped;
        return res;
    endfunction

    function automatic mvt_pkg::elem_t random_elem(val_kind_t kind);
        val_kind_t pick;
        pick = kind;
        if (pick == VAL_MIXED)
            pick = val_kind_t'($urandom_range(0, 2));
        case (pick)
            VAL_SMALL:
                return mvt_pkg::elem_t'(int'($urandom_range(0, 32'h0010_0000))
                                        - 32'h0008_0000);
            VAL_EXTREME:
                case ($urandom_range(0, 7))
                    0: return mvt_pkg::SAT_MIN;
                    1: return mvt_pkg::SAT_MAX;
                    2: return '0;
                    3: return -1;
                    4: return 1;
                    5: return FIX_ONE;
                    6: return -FIX_ONE;
                    default: return mvt_pkg::SAT_MIN + 1;
                endcase
            default:
                return mvt_pkg::elem_t'($urandom);
        endcase
    endfunction

    function automatic mvt_pkg::mvt_in_t random_vector(val_kind_t kind);
        return '{random_elem(kind), random_elem(kind), random_elem(kind), random_elem(kind)};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic write_reg(logic [mvt_pkg::CFG_INDEX_W-1:0] index,
                             logic [mvt_pkg::REG_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index < mvt_pkg::NUM_REGS)
            matrix_regs[index] = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_matrix(logic [mvt_pkg::REG_W-1:0] regs [mvt_pkg::NUM_REGS]);
        for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
            write_reg(mvt_pkg::CFG_INDEX_W'(i), regs[i]);
    endtask

    task automatic write_uniform_matrix(mvt_pkg::elem_t value);
        logic [mvt_pkg::REG_W-1:0] regs [mvt_pkg::NUM_REGS];
        for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
            regs[i] = {value, value};
        write_matrix(regs);
    endtask

    task automatic write_identity();
        logic [mvt_pkg::REG_W-1:0] regs [mvt_pkg::NUM_REGS];
        for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
            regs[i] = '0;
        regs[mvt_pkg::REG_ROW0_COLS01] = {32'd0, FIX_ONE};
        regs[mvt_pkg::REG_ROW1_COLS01] = {FIX_ONE, 32'd0};
        regs[mvt_pkg::REG_ROW2_COLS23] = {32'd0, FIX_ONE};
        regs[mvt_pkg::REG_ROW3_COLS23] = {FIX_ONE, 32'd0};
        write_matrix(regs);
    endtask

    task automatic write_random_matrix(val_kind_t kind);
        logic [mvt_pkg::REG_W-1:0] regs [mvt_pkg::NUM_REGS];
        for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
            regs[i] = {random_elem(kind), random_elem(kind)};
        write_matrix(regs);
    endtask

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_vector(mvt_pkg::mvt_in_t vec);
        int gap;
        gap = sender_gaps ? random_gap() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = vec;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // pipe must be empty before the matrix changes
    task automatic settle();
        drain_results();
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    task automatic check_identity_passthrough();
        send_vector('{mvt_pkg::elem_t'(0), mvt_pkg::elem_t'(0),
                      mvt_pkg::elem_t'(0), mvt_pkg::elem_t'(0)});
        send_vector('{mvt_pkg::SAT_MAX, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MIN});
        send_vector('{mvt_pkg::elem_t'(-1), mvt_pkg::elem_t'(1), FIX_ONE, -FIX_ONE});
        send_vector('{mvt_pkg::SAT_MIN, mvt_pkg::SAT_MAX, mvt_pkg::elem_t'(-1),
                      mvt_pkg::elem_t'(0)});
        send_vector(random_vector(VAL_FULL));
        settle();
    endtask

    task automatic check_ignored_register_index();
        for (int idx = mvt_pkg::NUM_REGS; idx < (1 << mvt_pkg::CFG_INDEX_W); idx++)
            write_reg(mvt_pkg::CFG_INDEX_W'(idx), {$urandom, $urandom});
        send_vector(random_vector(VAL_SMALL));
        send_vector(random_vector(VAL_FULL));
        settle();
    endtask

    task automatic check_extreme_products();
        // products of -2^31 * -2^31 overflow 64 bits once summed
        write_uniform_matrix(mvt_pkg::SAT_MIN);
        send_vector('{mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN});
        send_vector('{mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX});
        send_vector('{mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX});
        send_vector('{mvt_pkg::elem_t'(0), mvt_pkg::elem_t'(-1),
                      mvt_pkg::elem_t'(1), mvt_pkg::elem_t'(0)});
        settle();
        write_uniform_matrix(mvt_pkg::SAT_MAX);
        send_vector('{mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MAX});
        send_vector('{mvt_pkg::SAT_MIN, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MAX});
        send_vector('{mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MIN});
        settle();
    endtask

    task automatic check_floor_rounding();
        logic [mvt_pkg::REG_W-1:0] regs [mvt_pkg::NUM_REGS];
        regs[mvt_pkg::REG_ROW0_COLS01] = {32'd0, 32'd1};
        regs[REG_ROW0_COLS23]          = '0;
        regs[mvt_pkg::REG_ROW1_COLS01] = {2{32'hffff_ffff}};
        regs[REG_ROW1_COLS23]          = {2{32'hffff_ffff}};
        regs[REG_ROW2_COLS01]          = '0;
        regs[mvt_pkg::REG_ROW2_COLS23] = {32'd1, 32'd1};
        regs[REG_ROW3_COLS01]          = {32'd0, 32'hffff_8000};
        regs[mvt_pkg::REG_ROW3_COLS23] = '0;
        write_matrix(regs);
        send_vector('{mvt_pkg::elem_t'(-1), mvt_pkg::elem_t'(1),
                      mvt_pkg::elem_t'(-65537), mvt_pkg::elem_t'(65535)});
        send_vector('{mvt_pkg::elem_t'(1), mvt_pkg::elem_t'(-1), FIX_ONE, -FIX_ONE});
        send_vector('{mvt_pkg::elem_t'(0), mvt_pkg::elem_t'(0),
                      mvt_pkg::elem_t'(-1), mvt_pkg::elem_t'(-1)});
        send_vector('{mvt_pkg::elem_t'(32768), mvt_pkg::elem_t'(32768),
                      mvt_pkg::elem_t'(1), mvt_pkg::elem_t'(-2)});
        send_vector('{mvt_pkg::SAT_MIN, mvt_pkg::SAT_MAX, mvt_pkg::SAT_MIN, mvt_pkg::SAT_MAX});
        settle();
    endtask

    task automatic check_random_transforms();
        val_kind_t vec_kind;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 6)
                0: write_random_matrix(VAL_FULL);
                1: write_random_matrix(VAL_SMALL);
                2: write_identity();
                3: write_random_matrix(VAL_EXTREME);
                4: write_uniform_matrix('0);
                default: write_random_matrix(VAL_MIXED);
            endcase
            vec_kind = (phase % 3 == 0) ? VAL_MIXED : (phase % 3 == 1) ? VAL_SMALL : VAL_FULL;
            // back-to-back input in some phases
            sender_gaps = (phase % 4 != 1);
            for (int item = 0; item < ITEMS_PER_PHASE; item++)
            begin
                if (phase == 3 && item == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_vector(random_vector(vec_kind));
            end
            settle();
        end
        sender_gaps = 1'b1;
    endtask

    // output side backpressure
    initial
    begin
        int go_len;
        int hold_len;
        int r;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            go_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
            out_stall = 1'b0;
            repeat (go_len) @(negedge clk);
            r = $urandom_range(0, 99);
            if (r < 75)
                hold_len = $urandom_range(1, 3);
            else if (r < 95)
                hold_len = $urandom_range(4, 10);
            else
                hold_len = $urandom_range(20, 60);
            out_stall = 1'b1;
            repeat (hold_len) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            pending_results.push_back(transform_vector(in_data));
    end

    task automatic report_field(string field, logic signed [31:0] want, logic signed [31:0] got);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected output transaction, expected none actual %h",
                         $time, out_data);
                mismatch_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (out_data.out_x !== oldest_result.out_x)
                    report_field("out_x", oldest_result.out_x, out_data.out_x);
                if (out_data.out_y !== oldest_result.out_y)
                    report_field("out_y", oldest_result.out_y, out_data.out_y);
                if (out_data.out_z !== oldest_result.out_z)
                    report_field("out_z", oldest_result.out_z, out_data.out_z);
                if (out_data.out_w !== oldest_result.out_w)
                    report_field("out_w", oldest_result.out_w, out_data.out_w);
                if (out_data.saturated !== oldest_result.saturated)
                    report_field("saturated", oldest_result.saturated, out_data.saturated);
            end
        end
    end

    // ends the run when no transaction of any kind happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        sender_gaps    = 1'b1;
        // matrix comes out of reset as the identity
        for (int i = 0; i < mvt_pkg::NUM_REGS; i++)
            matrix_regs[i] = '0;
        matrix_regs[mvt_pkg::REG_ROW0_COLS01] = {32'd0, FIX_ONE};
        matrix_regs[mvt_pkg::REG_ROW1_COLS01] = {FIX_ONE, 32'd0};
        matrix_regs[mvt_pkg::REG_ROW2_COLS23] = {32'd0, FIX_ONE};
        matrix_regs[mvt_pkg::REG_ROW3_COLS23] = {FIX_ONE, 32'd0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        check_identity_passthrough();
        check_ignored_register_index();
        check_extreme_products();
        check_floor_rounding();
        check_random_transforms();

        drain_results();
        repeat (4 * PIPE_LATENCY) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
